[src/skvt_pkg.sv]
// Shared types and constants for the sorted key/value table.
// No dependencies; the table top level and skvt_cell use this package.
`default_nettype none
package skvt_pkg;
	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned OPC_W = 2;
	localparam int unsigned CNT_OUT_W = 7;

	typedef enum logic [OPC_W-1:0] {
		OP_PUT   = 2'd0,
		OP_SORT  = 2'd1,
		OP_GET   = 2'd2,
		OP_CLEAR = 2'd3
	} skvt_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_SRCH,
		ST_DONE
	} skvt_state_t;

	// Per-cell control: load from the write port, or take a neighbor's entry.
	typedef struct packed {
		logic wr;
		logic take_right;
		logic take_left;
	} skvt_cell_ctrl_t;
endpackage
`default_nettype wire

[src/sorted_key_value_table.sv]
// Top level of the sorted key/value table: the row of cells and its sequencer.
// Depends on skvt_pkg and skvt_cell.
//
// The table is a row of TABLE_DEPTH cells, each holding one key and value. A put
// writes the cell at the fill count; a put into a full table is dropped and
// reported with status 1. A clear resets the fill count. A put or a clear goes
// through the done state, which hands its result to the output register. A sort
// runs an odd-even transposition over the row, one phase per cycle, for as many
// phases as there are entries (at least one); neighbors swap only on a strictly
// greater key, so equal keys keep their order. A get binary-searches the row,
// one probe per cycle; a miss ends once the search range is empty. A stalled
// output holds the item in the done state until the output register is free.
// One item is in work at a time; the next item is taken once the previous one
// has moved to the output register, even while that result is still stalled.
`default_nettype none
module sorted_key_value_table #(
	parameter int unsigned TABLE_DEPTH = skvt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [skvt_pkg::OPC_W-1:0]         opcode,
	input  wire logic [skvt_pkg::KEY_W-1:0]         key,
	input  wire logic [skvt_pkg::VAL_W-1:0]         entry_value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    found,
	output logic      [skvt_pkg::VAL_W-1:0]         lookup_value,
	output logic                                    status,
	output logic      [skvt_pkg::CNT_OUT_W-1:0]     entry_count
);
	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	skvt_pkg::skvt_state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [CW-1:0] pass_q;
	logic [CW-1:0] lo_q, hi_q;
	logic [skvt_pkg::KEY_W-1:0] srch_key_q;
	logic res_found_q, res_status_q;
	logic [skvt_pkg::VAL_W-1:0] res_value_q;
	logic out_valid_q, found_q, status_q;
	logic [skvt_pkg::VAL_W-1:0] lookup_value_q;
	logic [skvt_pkg::CNT_OUT_W-1:0] entry_count_q;

	logic accept, out_free, is_put, is_full;
	logic sort_last, srch_active;
	logic [CW-1:0] diff, mid_wide;
	logic [AW-1:0] mid;

	logic [skvt_pkg::KEY_W-1:0] cell_key_w   [TABLE_DEPTH];
	logic [skvt_pkg::VAL_W-1:0] cell_value_w [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] lt_w, eq_w;
	logic [TABLE_DEPTH-1:0] swap_w;
	skvt_pkg::skvt_cell_ctrl_t ctrl_w [TABLE_DEPTH];

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign is_put   = skvt_pkg::skvt_op_t'(opcode) == skvt_pkg::OP_PUT;
	assign is_full  = count_q >= CW'(TABLE_DEPTH);

	// A sort with n entries needs n phases; pass_q counts them.
	assign sort_last   = (pass_q + CW'(1)) >= count_q;
	assign srch_active = lo_q < hi_q;
	assign diff        = hi_q - lo_q - CW'(1);
	assign mid_wide    = lo_q + (diff >> 1);
	assign mid         = mid_wide[AW-1:0];

	// Cell i pairs with cell i+1 in phases whose parity matches i.
	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			logic [skvt_pkg::KEY_W-1:0] rk;
			logic [skvt_pkg::VAL_W-1:0] rv;
			logic [skvt_pkg::KEY_W-1:0] lk;
			logic [skvt_pkg::VAL_W-1:0] lv;
			if (gi + 1 < TABLE_DEPTH) begin : g_r
				assign rk = cell_key_w[gi+1];
				assign rv = cell_value_w[gi+1];
				assign swap_w[gi] = (state_q == skvt_pkg::ST_SORT)
					&& (pass_q[0] == 1'(gi % 2))
					&& (CW'(gi + 1) < count_q)
					&& (cell_key_w[gi] > cell_key_w[gi+1]);
			end else begin : g_rn
				assign rk = cell_key_w[gi];
				assign rv = cell_value_w[gi];
				assign swap_w[gi] = 1'b0;
			end
			if (gi > 0) begin : g_l
				assign lk = cell_key_w[gi-1];
				assign lv = cell_value_w[gi-1];
				assign ctrl_w[gi].take_left = swap_w[gi-1];
			end else begin : g_ln
				assign lk = cell_key_w[gi];
				assign lv = cell_value_w[gi];
				assign ctrl_w[gi].take_left = 1'b0;
			end
			assign ctrl_w[gi].take_right = swap_w[gi];
			assign ctrl_w[gi].wr = accept && is_put && (count_q == CW'(gi));

			skvt_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl_w[gi]),
				.wr_key     (key),
				.wr_value   (entry_value),
				.left_key   (lk),
				.left_value (lv),
				.right_key  (rk),
				.right_value(rv),
				.srch_key   (srch_key_q),
				.cell_key   (cell_key_w[gi]),
				.cell_value (cell_value_w[gi]),
				.srch_lt    (lt_w[gi]),
				.srch_eq    (eq_w[gi])
			);
		end
	endgenerate

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			skvt_pkg::ST_IDLE: begin
				if (accept) begin
					case (skvt_pkg::skvt_op_t'(opcode))
						skvt_pkg::OP_SORT: state_d = skvt_pkg::ST_SORT;
						skvt_pkg::OP_GET:  state_d = skvt_pkg::ST_SRCH;
						default:           state_d = skvt_pkg::ST_DONE;
					endcase
				end
			end
			skvt_pkg::ST_SORT: begin
				if (sort_last || count_q <= CW'(1)) state_d = skvt_pkg::ST_DONE;
			end
			skvt_pkg::ST_SRCH: begin
				if (!srch_active || eq_w[mid]) state_d = skvt_pkg::ST_DONE;
			end
			skvt_pkg::ST_DONE: begin
				if (out_free) state_d = skvt_pkg::ST_IDLE;
			end
			default: state_d = skvt_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall = 1'b1;
		case (state_q)
			skvt_pkg::ST_IDLE: in_stall = 1'b0;
			default:           in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skvt_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (skvt_pkg::skvt_op_t'(opcode))
					skvt_pkg::OP_PUT:   if (!is_full) count_q <= count_q + CW'(1);
					skvt_pkg::OP_CLEAR: count_q <= '0;
					default:            ;
				endcase
			end
			if (state_q == skvt_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Work registers and result holding.
	always_ff @(posedge clk) begin
		if (accept) begin
			srch_key_q   <= key;
			pass_q       <= '0;
			lo_q         <= '0;
			hi_q         <= count_q;
			res_found_q  <= 1'b0;
			res_value_q  <= '0;
			res_status_q <= is_put && is_full;
		end
		if (state_q == skvt_pkg::ST_SORT) begin
			pass_q <= pass_q + CW'(1);
		end
		if (state_q == skvt_pkg::ST_SRCH && srch_active) begin
			if (eq_w[mid]) begin
				res_found_q <= 1'b1;
				res_value_q <= cell_value_w[mid];
			end else if (lt_w[mid]) begin
				hi_q <= mid_wide;
			end else begin
				lo_q <= mid_wide + CW'(1);
			end
		end
		if (state_q == skvt_pkg::ST_DONE && out_free) begin
			found_q        <= res_found_q;
			lookup_value_q <= res_value_q;
			status_q       <= res_status_q;
			entry_count_q  <= skvt_pkg::CNT_OUT_W'(count_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign lookup_value = lookup_value_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;
endmodule
`default_nettype wire

[src/skvt_cell.sv]
// One storage cell of the sorted key/value table: a key, a value and compares.
// Depends on skvt_pkg.
`default_nettype none
module skvt_cell (
	input  wire logic                         clk,
	input  wire skvt_pkg::skvt_cell_ctrl_t    ctrl,
	input  wire logic [skvt_pkg::KEY_W-1:0]   wr_key,
	input  wire logic [skvt_pkg::VAL_W-1:0]   wr_value,
	input  wire logic [skvt_pkg::KEY_W-1:0]   left_key,
	input  wire logic [skvt_pkg::VAL_W-1:0]   left_value,
	input  wire logic [skvt_pkg::KEY_W-1:0]   right_key,
	input  wire logic [skvt_pkg::VAL_W-1:0]   right_value,
	input  wire logic [skvt_pkg::KEY_W-1:0]   srch_key,
	output logic      [skvt_pkg::KEY_W-1:0]   cell_key,
	output logic      [skvt_pkg::VAL_W-1:0]   cell_value,
	output logic                              srch_lt,
	output logic                              srch_eq
);
	logic [skvt_pkg::KEY_W-1:0] key_q;
	logic [skvt_pkg::VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			key_q   <= wr_key;
			value_q <= wr_value;
		end else if (ctrl.take_right) begin
			key_q   <= right_key;
			value_q <= right_value;
		end else if (ctrl.take_left) begin
			key_q   <= left_key;
			value_q <= left_value;
		end
	end

	assign cell_key   = key_q;
	assign cell_value = value_q;
	assign srch_lt    = srch_key < key_q;
	assign srch_eq    = srch_key == key_q;
endmodule
`default_nettype wire

[src/skvt_checker.sv]
// Port-level checks for the sorted key/value table, bound to its top level.
// Depends on sorted_key_value_table.
`default_nettype none
module skvt_port_checks (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        found,
	input wire logic [31:0] lookup_value,
	input wire logic        status
);
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(lookup_value))
		else $error("stalled result changed");

	// A dropped put never reports a hit.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(status && found))
		else $error("status and found both set");

	// A miss reports value zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> lookup_value == 32'd0)
		else $error("miss with nonzero value");

	// One item at a time: the block is busy the cycle after it takes an item.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while busy");
endmodule

bind sorted_key_value_table skvt_port_checks u_skvt_port_checks (.*);
`default_nettype wire
